// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the frame FIFO.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frame FIFO check failed");

// Next-cycle implication, sampled on aclk and held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frame FIFO check failed");

`endif

// ===== hw/rtl/lfbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame FIFO package
// Constants, result codes, controller states and the command and status
// structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package lfbf_pkg;

    localparam int STORE_DEPTH  = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int LEN_OFFSET   = 2;
    localparam int LEN_BYTES    = 4;

    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int COUNT_W   = ADDR_W + 1;
    localparam int SIZE_W    = 13;
    localparam int CMP_W     = (COUNT_W > SIZE_W) ? COUNT_W : SIZE_W;
    localparam int LEN_W     = 8 * LEN_BYTES;
    localparam int HIDX_W    = $clog2(LEN_BYTES);
    localparam int IN_DATA_W = 8 + SIZE_W;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_DROPPED = 2'd1,
        ST_BYTE    = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_HDR_READ,
        S_HDR_TAKE,
        S_CHECK,
        S_POP_WAIT,
        S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic exec_write;
        logic hdr_read;
        logic hdr_take;
        logic set_none;
        logic start_frame;
        logic pop_read;
        logic pop_take;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic frame_idle;
        logic short_fill;
        logic hdr_last;
        logic too_long;
        logic out_busy;
    } sts_t;

endpackage

// ===== hw/rtl/lfbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame FIFO controller
// Sequences one request at a time: write decision, header fetch, length
// check, byte pop and hand-over to the output register.
// ----------------------------------------------------------------------------
module lfbf_ctrl
    import lfbf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!sts.is_read) begin
                    cmd.exec_write = 1'b1;
                    state_next     = S_RESULT;
                end else if (!sts.frame_idle) begin
                    cmd.pop_read = 1'b1;
                    state_next   = S_POP_WAIT;
                end else if (sts.short_fill) begin
                    cmd.set_none = 1'b1;
                    state_next   = S_RESULT;
                end else begin
                    cmd.hdr_read = 1'b1;
                    state_next   = S_HDR_TAKE;
                end
            end
            S_HDR_READ: begin
                cmd.hdr_read = 1'b1;
                state_next   = S_HDR_TAKE;
            end
            S_HDR_TAKE: begin
                cmd.hdr_take = 1'b1;
                state_next   = sts.hdr_last ? S_CHECK : S_HDR_READ;
            end
            S_CHECK: begin
                if (sts.too_long) begin
                    cmd.set_none = 1'b1;
                    state_next   = S_RESULT;
                end else begin
                    cmd.start_frame = 1'b1;
                    cmd.pop_read    = 1'b1;
                    state_next      = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                cmd.pop_take = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lfbf_datapath.sv =====
// ----------------------------------------------------------------------------
// Frame FIFO datapath
// Byte store, pointers, counters, header length register, result register
// and output register.
// ----------------------------------------------------------------------------
module lfbf_datapath
    import lfbf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 in_action,
    input  logic                 in_chunk_first,
    input  logic [IN_DATA_W-1:0] in_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    logic [7:0]        store_mem [STORE_DEPTH];
    logic [7:0]        rd_data_reg;

    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [COUNT_W-1:0] fill_reg;
    logic [COUNT_W-1:0] fbl_reg;
    logic               dropping_reg;
    logic [SIZE_W-1:0]  chunk_left_reg;

    logic               action_reg;
    logic               first_in_reg;
    logic [7:0]         byte_in_reg;
    logic [SIZE_W-1:0]  size_in_reg;

    logic [HIDX_W-1:0]  hidx_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               starting_reg;

    status_t            res_status_reg;
    logic [7:0]         res_byte_reg;
    logic               res_first_reg;
    logic               res_last_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [7:0]         out_byte_reg;
    logic               out_first_reg;
    logic               out_last_reg;

    logic [CMP_W-1:0]   room;
    logic [CMP_W-1:0]   size_ext;
    logic               first_ok;
    logic               next_ok;
    logic               push;
    logic [LEN_W:0]     frame_total;
    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_re;

    assign room     = CMP_W'(COUNT_W'(STORE_DEPTH) - fill_reg);
    assign size_ext = CMP_W'(size_in_reg);
    assign first_ok = (size_in_reg != '0) && (size_ext <= room);
    assign next_ok  = !dropping_reg && (chunk_left_reg != '0)
                      && (fill_reg < COUNT_W'(STORE_DEPTH));
    assign push     = cmd.exec_write && (first_in_reg ? first_ok : next_ok);

    assign frame_total = {1'b0, len_reg} + (LEN_W + 1)'(HEADER_BYTES);

    always_comb begin
        mem_addr = rd_ptr_reg;
        if (cmd.exec_write) begin
            mem_addr = wr_ptr_reg;
        end else if (cmd.hdr_read) begin
            mem_addr = rd_ptr_reg + ADDR_W'(LEN_OFFSET) + ADDR_W'(hidx_reg);
        end
    end

    assign mem_re = cmd.hdr_read || cmd.pop_read;

    always_ff @(posedge aclk) begin
        if (push) begin
            store_mem[mem_addr] <= byte_in_reg;
        end
        if (mem_re) begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
            fbl_reg        <= '0;
            dropping_reg   <= 1'b0;
            chunk_left_reg <= '0;
        end else begin
            if (cmd.exec_write) begin
                if (first_in_reg) begin
                    dropping_reg   <= !first_ok;
                    chunk_left_reg <= first_ok ? size_in_reg - SIZE_W'(1) : '0;
                end else if (next_ok) begin
                    chunk_left_reg <= chunk_left_reg - SIZE_W'(1);
                end
            end
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + ADDR_W'(1);
                fill_reg   <= fill_reg + COUNT_W'(1);
            end
            if (cmd.start_frame) begin
                fbl_reg <= frame_total[COUNT_W-1:0];
            end
            if (cmd.pop_take) begin
                rd_ptr_reg <= rd_ptr_reg + ADDR_W'(1);
                fill_reg   <= fill_reg - COUNT_W'(1);
                fbl_reg    <= fbl_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg   <= in_action;
            first_in_reg <= in_chunk_first;
            byte_in_reg  <= in_data[7:0];
            size_in_reg  <= in_data[IN_DATA_W-1:8];
            hidx_reg     <= '0;
            starting_reg <= 1'b0;
        end
        if (cmd.hdr_take) begin
            len_reg  <= {rd_data_reg, len_reg[LEN_W-1:8]};
            hidx_reg <= hidx_reg + HIDX_W'(1);
        end
        if (cmd.start_frame) begin
            starting_reg <= 1'b1;
        end
        if (cmd.exec_write) begin
            res_status_reg <= push ? ST_WRITTEN : ST_DROPPED;
            res_byte_reg   <= '0;
            res_first_reg  <= 1'b0;
            res_last_reg   <= 1'b0;
        end else if (cmd.set_none) begin
            res_status_reg <= ST_NONE;
            res_byte_reg   <= '0;
            res_first_reg  <= 1'b0;
            res_last_reg   <= 1'b0;
        end else if (cmd.pop_take) begin
            res_status_reg <= ST_BYTE;
            res_byte_reg   <= rd_data_reg;
            res_first_reg  <= starting_reg;
            res_last_reg   <= (fbl_reg == COUNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_byte_reg   <= res_byte_reg;
            out_first_reg  <= res_first_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    assign sts.is_read    = action_reg;
    assign sts.frame_idle = (fbl_reg == '0);
    assign sts.short_fill = (fill_reg < COUNT_W'(HEADER_BYTES));
    assign sts.hdr_last   = (hidx_reg == HIDX_W'(LEN_BYTES - 1));
    assign sts.too_long   = (frame_total > (LEN_W + 1)'(fill_reg));
    assign sts.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_first_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/length_framed_byte_fifo_core.sv =====
// A write request is decided in S_DECIDE and handed on in S_RESULT. A pop
// inside a running frame passes S_POP_WAIT; a frame start first makes the four
// header length reads through the single-port byte store and the length check.
// One request is in flight at a time; the next is taken once the result is in
// the output register. aresetn (synchronous, active low) empties the store and
// clears the pointers, the fill, frame and chunk counters and output valid flag.
// ----------------------------------------------------------------------------
// Length-framed byte FIFO core
// Byte FIFO holding length-prefixed frames, written byte by byte in chunks and read
// one frame byte per request.
// ----------------------------------------------------------------------------
module length_framed_byte_fifo_core
    import lfbf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [7:0] data_byte, [20:8] chunk_size, [23:21] zero
    input  logic [1:0]  s_tuser,  // [0] action, [1] chunk_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [7:0] byte_out
    output logic [2:0]  m_tuser,  // [1:0] status, [2] frame_first
    output logic        m_tlast
);

    cmd_t cmd;
    sts_t sts;

    lfbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfbf_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_action      (s_tuser[0]),
        .in_chunk_first (s_tuser[1]),
        .in_data        (s_tdata[IN_DATA_W-1:0]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

// ===== hw/rtl/lfbf_checker.sv =====
// ----------------------------------------------------------------------------
// Frame FIFO port checker
// Checks seen on the top-level ports only, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfbf_checker
    import lfbf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    logic s_taken;
    logic not_byte;
    logic quiet_ok;

    assign s_taken  = s_tvalid && s_tready;
    assign not_byte = m_tuser[1:0] != ST_BYTE;
    assign quiet_ok = (m_tdata == 8'd0) && !m_tlast && !m_tuser[2];

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_one_at_a_time, s_taken, !s_tready)
    `ASSERT_SAME(a_quiet_payload, m_tvalid && not_byte, quiet_ok)
    `ASSERT_SAME(a_first_is_byte, m_tvalid && m_tuser[2], m_tuser[1:0] == ST_BYTE)

endmodule

bind length_framed_byte_fifo_core lfbf_checker u_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Frame FIFO core testbench
// Drives chunked byte writes and frame byte requests into the core with
// random idling on both sides. A scoreboard predicts every result from its
// own copy of the store, pointers and chunk state, and checks each returned
// result field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import lfbf_pkg::*;

    localparam bit ACT_WRITE    = 1'b0;
    localparam bit ACT_READ     = 1'b1;
    localparam int RANDOM_ITEMS = 2000;
    localparam int MAX_GAP      = 18;
    localparam int RUN_LIMIT    = 3_000_000;

    typedef struct {
        status_t    status;
        logic [7:0] data_out;
        logic       first;
        logic       last;
    } frame_result_t;

    class frame_fifo_scoreboard;
        logic [7:0]        store_mem [STORE_DEPTH];
        logic [ADDR_W-1:0] rd_ptr;
        logic [ADDR_W-1:0] wr_ptr;
        int unsigned       fill;
        longint unsigned   frame_left;
        bit                dropping;
        int unsigned       chunk_left;
        frame_result_t     expected_q[$];
        int unsigned       errors;

        function new();
            rd_ptr     = '0;
            wr_ptr     = '0;
            fill       = 0;
            frame_left = 0;
            dropping   = 1'b0;
            chunk_left = 0;
            errors     = 0;
        endfunction

        function void note_request(bit is_read, logic [7:0] data, bit first,
                                   logic [12:0] size);
            frame_result_t     res;
            longint unsigned   len;
            logic [ADDR_W-1:0] hdr_ptr;
            res = '{ST_WRITTEN, 8'h00, 1'b0, 1'b0};
            if (!is_read) begin
                if (first) begin
                    if (size == 0 || size > STORE_DEPTH - fill) begin
                        dropping   = 1'b1;
                        chunk_left = 0;
                        res.status = ST_DROPPED;
                    end else begin
                        dropping           = 1'b0;
                        store_mem[wr_ptr]  = data;
                        wr_ptr             = wr_ptr + 1'b1;
                        fill++;
                        chunk_left = size - 1;
                    end
                end else if (dropping || chunk_left == 0 || fill >= STORE_DEPTH) begin
                    res.status = ST_DROPPED;
                end else begin
                    store_mem[wr_ptr] = data;
                    wr_ptr            = wr_ptr + 1'b1;
                    fill++;
                    chunk_left--;
                end
            end else begin
                res.status = ST_NONE;
                if (frame_left == 0 && fill >= HEADER_BYTES) begin
                    len = 0;
                    for (int i = 0; i < LEN_BYTES; i++) begin
                        hdr_ptr = ADDR_W'(rd_ptr + LEN_OFFSET + i);
                        len     = len | (longint'(store_mem[hdr_ptr]) << (8 * i));
                    end
                    if (len + HEADER_BYTES <= fill) begin
                        frame_left = len + HEADER_BYTES;
                        res.first  = 1'b1;
                    end
                end
                if (frame_left != 0) begin
                    res.status   = ST_BYTE;
                    res.data_out = store_mem[rd_ptr];
                    rd_ptr       = rd_ptr + 1'b1;
                    fill--;
                    frame_left--;
                    res.last = (frame_left == 0);
                end
            end
            expected_q = {expected_q, res};
        endfunction

        function void check_result(status_t st, logic [7:0] d, logic f, logic l);
            frame_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got status %0d data %02h",
                         $time, st, d);
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (st !== want.status) begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, want.status, st);
            end
            if (d !== want.data_out) begin
                errors++;
                $display("%0t: byte expected %02h got %02h", $time, want.data_out, d);
            end
            if (f !== want.first) begin
                errors++;
                $display("%0t: frame first expected %0b got %0b", $time, want.first, f);
            end
            if (l !== want.last) begin
                errors++;
                $display("%0t: frame last expected %0b got %0b", $time, want.last, l);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] data_byte, [20:8] chunk_size, [23:21] zero
    logic [1:0]  s_tuser;   // [0] action, [1] chunk_first
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] byte_out
    logic [2:0]  m_tuser;   // [1:0] status, [2] frame_first
    logic        m_tlast;

    frame_fifo_scoreboard sb = new();
    logic [7:0]           frame_bytes_q[$];
    bit                   tx_quiet;
    bit                   rx_quiet;
    int unsigned          cycle_count = 0;

    length_framed_byte_fifo_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void queue_byte(int b);
        frame_bytes_q = {frame_bytes_q, 8'(b)};
    endfunction

    function automatic int next_byte();
        int b;
        b = int'(frame_bytes_q[0]);
        frame_bytes_q.delete(0);
        return b;
    endfunction

    task automatic send_request(bit is_read, int data, int first, int size);
        int gap;
        gap = pick_gap(tx_quiet);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, 13'(size), 8'(data)};
        s_tuser  = {1'(first), is_read};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(is_read, 8'(data), 1'(first), 13'(size));
    endtask

    task automatic read_bytes(int n);
        for (int i = 0; i < n; i++) begin
            send_request(ACT_READ, $urandom_range(0, 255), $urandom_range(0, 1),
                         $urandom_range(0, 8191));
        end
    endtask

    // Sends the next k queued bytes as one chunk that claims the given size.
    task automatic write_chunk(int k, int declared);
        for (int i = 0; i < k; i++) begin
            send_request(ACT_WRITE, next_byte(), int'(i == 0),
                         (i == 0) ? declared : $urandom_range(0, 8191));
        end
    endtask

    task automatic queue_header(logic [31:0] len);
        queue_byte($urandom_range(0, 255));
        queue_byte($urandom_range(0, 255));
        for (int i = 0; i < LEN_BYTES; i++) queue_byte(int'(len[8*i +: 8]));
        queue_byte($urandom_range(0, 255));
        queue_byte($urandom_range(0, 255));
    endtask

    task automatic queue_frame(int unsigned len);
        queue_header(len);
        for (int i = 0; i < len; i++) queue_byte($urandom_range(0, 255));
    endtask

    initial begin
        int gap;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = pick_gap(rx_quiet);
            @(negedge aclk);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(status_t'(m_tuser[1:0]), m_tdata, m_tuser[2], m_tlast);
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        end
    end

    initial begin
        int items_done;
        int k;
        int room;
        int declared;
        int pick;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        tx_quiet    = 1'b0;
        items_done  = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed opening: empty store, stray and dropped chunks, an abandoned
        // full-size chunk, and a frame whose header arrives before its payload.
        read_bytes(1);
        send_request(ACT_WRITE, $urandom_range(0, 255), 0, $urandom_range(0, 8191));
        send_request(ACT_WRITE, $urandom_range(0, 255), 1, 0);
        send_request(ACT_WRITE, $urandom_range(0, 255), 0, $urandom_range(0, 8191));
        send_request(ACT_WRITE, $urandom_range(0, 255), 1, 8191);
        queue_frame(1);
        write_chunk(1, STORE_DEPTH);
        write_chunk(5, 5);
        send_request(ACT_WRITE, $urandom_range(0, 255), 0, $urandom_range(0, 8191));
        read_bytes(1);
        write_chunk(2, 2);
        read_bytes(1);
        write_chunk(1, 1);
        read_bytes(9);

        while (items_done < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
            if (frame_bytes_q.size() < HEADER_BYTES) begin
                queue_frame(($urandom_range(0, 15) == 0) ? $urandom_range(25, 300)
                                                         : $urandom_range(0, 24));
            end
            pick = $urandom_range(0, 99);
            room = STORE_DEPTH - sb.fill;
            k    = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 64 : 16);
            if (k > frame_bytes_q.size()) k = frame_bytes_q.size();
            if (pick < 55 && k <= room) begin
                declared = k;
                if ($urandom_range(0, 5) == 0) begin
                    declared = k + $urandom_range(1, 6);
                    if (declared > room) declared = room;
                end
                write_chunk(k, declared);
                items_done += k;
            end else if (pick < 90 || k > room) begin
                k = $urandom_range(1, 12);
                read_bytes(k);
                items_done += k;
            end else begin
                case ($urandom_range(0, 2))
                    0: send_request(ACT_WRITE, $urandom_range(0, 255), 1, 0);
                    1: send_request(ACT_WRITE, $urandom_range(0, 255), 1,
                                    $urandom_range(room + 1, 8191));
                    default: begin
                        if (sb.chunk_left == 0) begin
                            send_request(ACT_WRITE, $urandom_range(0, 255), 0,
                                         $urandom_range(0, 8191));
                        end
                    end
                endcase
                repeat ($urandom_range(0, 3)) begin
                    if (sb.dropping) begin
                        send_request(ACT_WRITE, $urandom_range(0, 255), 0,
                                     $urandom_range(0, 8191));
                    end
                end
            end
        end

        // Flush what is queued and empty the store completely.
        while (frame_bytes_q.size() > 0) begin
            room = STORE_DEPTH - sb.fill;
            if (room == 0) begin
                read_bytes(8);
            end else begin
                k = frame_bytes_q.size();
                if (k > 32) k = 32;
                if (k > room) k = room;
                write_chunk(k, k);
            end
        end
        while (sb.fill != 0) read_bytes(1);

        // One frame that fills the store exactly; nothing more fits after it.
        queue_frame(STORE_DEPTH - HEADER_BYTES);
        while (frame_bytes_q.size() > 0) begin
            k = $urandom_range(1, 256);
            if (k > frame_bytes_q.size()) k = frame_bytes_q.size();
            write_chunk(k, k);
        end
        send_request(ACT_WRITE, $urandom_range(0, 255), 1, 1);
        send_request(ACT_WRITE, $urandom_range(0, 255), 0, $urandom_range(0, 8191));
        read_bytes(STORE_DEPTH);

        // A length beyond the capacity never lets its frame start.
        queue_header(32'hFFFF_FFFF);
        write_chunk(HEADER_BYTES, HEADER_BYTES);
        read_bytes(3);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
